// ----- rtl/digitizer_bank_record_parser_core_macros.svh -----
// Assertion macros for the digitizer bank record parser core.
`ifndef DIGITIZER_BANK_RECORD_PARSER_CORE_MACROS_SVH
`define DIGITIZER_BANK_RECORD_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DBRP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dbrp assertion failed");
`define DBRP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbrp assertion failed");
`else
`define DBRP_ASSERT_IMP(label, ante, cons)
`define DBRP_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- rtl/dbrp_pkg.sv -----
// Shared types and constants of the digitizer bank record parser.
`default_nettype none
package dbrp_pkg;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 152;

	typedef enum logic [2:0] {
		KIND_STATUS   = 3'd0,
		KIND_HEADER   = 3'd1,
		KIND_SAMPLE   = 3'd2,
		KIND_MISMATCH = 3'd3,
		KIND_BAD_LEN  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [31:0] word;
		logic        first_word;
		logic [23:0] bank_words;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] error_mask;
		logic [47:0] time_stamp;
		logic [26:0] wave_length;
		logic [3:0]  info_nibble;
		logic [3:0]  trigger_count;
		logic        wrap_flag;
		logic [15:0] sample_first;
		logic [15:0] sample_second;
		logic        last_of_record;
		logic        truncated;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/dbrp_in_reg.sv -----
// Input register stage: holds one accepted word until the parser takes it.
`default_nettype none
module dbrp_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire dbrp_pkg::item_t in_item,
	input  wire logic           room,
	output logic                step,
	output logic                item_valid,
	output dbrp_pkg::item_t     item
);

	logic            valid_s1;
	dbrp_pkg::item_t item_s1;

	assign step       = valid_s1 && room;
	assign in_ready   = !valid_s1 || step;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dbrp_parse.sv -----
// Bank parser: phase tracking, header assembly and result formation per word.
`default_nettype none
module dbrp_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire dbrp_pkg::item_t item,
	output logic                 res_valid,
	output dbrp_pkg::res_t       res
);

	typedef enum logic [7:0] {
		PH_IDLE = 8'b0000_0001,
		PH_ERR  = 8'b0000_0010,
		PH_HDR0 = 8'b0000_0100,
		PH_HDR1 = 8'b0000_1000,
		PH_HDR2 = 8'b0001_0000,
		PH_HDR3 = 8'b0010_0000,
		PH_SAMP = 8'b0100_0000,
		PH_SKIP = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] word_offset_q, word_offset_d;
	logic [23:0] bank_length_q, bank_length_d;
	logic [31:0] size_word_q, size_word_d;
	logic [31:0] held_word_q, held_word_d;
	logic [47:0] held_time_q, held_time_d;
	logic [25:0] samples_left_q, samples_left_d;

	logic [23:0] wo_next;
	logic        record_ok;
	logic        at_end_pre;
	logic        at_end_post;
	logic        size_ok;
	logic [26:0] len;
	logic [11:0] info;
	logic        bad_len;
	logic        trunc_hdr;
	logic [25:0] left_dec;
	logic        has_res;

	function automatic logic [23:0] two_pieces(input logic [31:0] w);
		return {w[27:16], w[11:0]};
	endfunction

	assign wo_next     = word_offset_q + 24'd1;
	assign record_ok   = ({1'b0, wo_next} + 25'd4) < {1'b0, bank_length_q};
	assign at_end_pre  = word_offset_q >= bank_length_q;
	assign at_end_post = wo_next >= bank_length_q;
	assign size_ok     = size_word_q[31:1] == ({7'd0, bank_length_q} - 31'd2);
	assign len         = {held_word_q[2:0], two_pieces(item.word)};
	assign info        = held_word_q[27:16];
	assign bad_len     = (len < 27'd8) || len[0];
	assign trunc_hdr   = {2'd0, bank_length_q - wo_next} < len[26:1];
	assign left_dec    = (samples_left_q != 26'd0) ? samples_left_q - 26'd1 : 26'd0;

	always_comb begin
		phase_d        = phase_q;
		word_offset_d  = word_offset_q;
		bank_length_d  = bank_length_q;
		size_word_d    = size_word_q;
		held_word_d    = held_word_q;
		held_time_d    = held_time_q;
		samples_left_d = samples_left_q;
		res            = '0;
		has_res        = 1'b0;
		if (item.first_word) begin
			bank_length_d = item.bank_words;
			size_word_d   = item.word;
			word_offset_d = 24'd1;
			phase_d       = (item.bank_words < 24'd4) ? PH_IDLE : PH_ERR;
		end else if (phase_q == PH_IDLE || phase_q == PH_SKIP || at_end_pre) begin
			phase_d = PH_IDLE;
		end else begin
			word_offset_d = wo_next;
			case (phase_q)
				PH_ERR: begin
					res.error_mask = item.word;
					has_res        = 1'b1;
					if (!size_ok) begin
						res.kind = dbrp_pkg::KIND_MISMATCH;
						phase_d  = PH_IDLE;
					end else begin
						res.kind = dbrp_pkg::KIND_STATUS;
						phase_d  = record_ok ? PH_HDR0 : PH_SKIP;
					end
				end
				PH_HDR0: begin
					held_word_d = item.word;
					phase_d     = PH_HDR1;
				end
				PH_HDR1: begin
					held_time_d = {two_pieces(held_word_q), two_pieces(item.word)};
					phase_d     = PH_HDR2;
				end
				PH_HDR2: begin
					held_word_d = item.word;
					phase_d     = PH_HDR3;
				end
				PH_HDR3: begin
					has_res           = 1'b1;
					res.time_stamp    = held_time_q;
					res.wave_length   = len;
					res.info_nibble   = info[3:0];
					res.trigger_count = info[7:4];
					res.wrap_flag     = info[11];
					if (bad_len) begin
						res.kind = dbrp_pkg::KIND_BAD_LEN;
						phase_d  = PH_SKIP;
					end else begin
						res.kind       = dbrp_pkg::KIND_HEADER;
						samples_left_d = len[26:1];
						res.truncated  = trunc_hdr;
						phase_d        = PH_SAMP;
					end
				end
				PH_SAMP: begin
					has_res           = 1'b1;
					res.kind          = dbrp_pkg::KIND_SAMPLE;
					res.sample_first  = item.word[15:0];
					res.sample_second = item.word[31:16];
					samples_left_d    = left_dec;
					if (left_dec == 26'd0) begin
						res.last_of_record = 1'b1;
						phase_d            = record_ok ? PH_HDR0 : PH_SKIP;
					end else begin
						res.truncated = at_end_post;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			// close the bank once its last word is in
			if (at_end_post) begin
				phase_d = PH_IDLE;
			end
		end
	end

	assign res_valid = step && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			word_offset_q  <= '0;
			bank_length_q  <= '0;
			size_word_q    <= '0;
			held_word_q    <= '0;
			held_time_q    <= '0;
			samples_left_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			word_offset_q  <= word_offset_d;
			bank_length_q  <= bank_length_d;
			size_word_q    <= size_word_d;
			held_word_q    <= held_word_d;
			held_time_q    <= held_time_d;
			samples_left_q <= samples_left_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dbrp_out_buf.sv -----
// Result register with a skid entry so that upstream ready is registered.
`default_nettype none
module dbrp_out_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dbrp_pkg::res_t push_res,
	output logic                room,
	output logic                out_valid,
	input  wire logic           out_ready,
	output dbrp_pkg::res_t      out_res
);

	logic           main_v_q;
	logic           skid_v_q;
	dbrp_pkg::res_t main_q;
	dbrp_pkg::res_t skid_q;
	logic           drain;

	assign room      = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;
	assign drain     = !main_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			main_q <= skid_v_q ? skid_q : push_res;
		end else if (push) begin
			// hold the new word aside while the output stalls
			skid_q <= push_res;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/digitizer_bank_record_parser_core.sv -----
// Top level of the digitizer bank record parser core.
// Takes one 32-bit bank word per cycle while the output is not stalled and gives at most one
// result word per input word: a status or size-mismatch word on bank word 1, a record header
// or bad-length word on the fourth header word of each record, and a sample-pair word for
// each sample word. The core sustains one word per clock while the output is not stalled;
// each word passes the input register and then the result register, or its skid entry,
// around the combinational parse logic.
// A two-entry result buffer keeps the input side ready after the output stalls until its skid entry is full.
// There is no initialization pass after reset.
`default_nettype none
`include "digitizer_bank_record_parser_core_macros.svh"
module digitizer_bank_record_parser_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [31:0] word, [55:32] bank_words
	input  wire logic [dbrp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [0] first_word
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [31:0] error_mask, [79:32] time_stamp, [106:80] wave_length, [110:107] info_nibble,
	// [114:111] trigger_count, [115] wrap_flag, [131:116] sample_first,
	// [147:132] sample_second, [148] truncated, [151:149] zero
	output logic [dbrp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	// [2:0] kind
	output logic [2:0]                              m_axis_tuser,
	output logic                                    m_axis_tlast
);

	dbrp_pkg::item_t in_item;
	dbrp_pkg::item_t item;
	dbrp_pkg::res_t  res;
	dbrp_pkg::res_t  out_res;
	logic            room;
	logic            step;
	logic            item_valid;
	logic            res_valid;

	assign in_item.word       = s_axis_tdata[31:0];
	assign in_item.bank_words = s_axis_tdata[55:32];
	assign in_item.first_word = s_axis_tuser;

	dbrp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.room       (room),
		.step       (step),
		.item_valid (item_valid),
		.item       (item)
	);

	dbrp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	dbrp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {3'd0, out_res.truncated, out_res.sample_second, out_res.sample_first,
		out_res.wrap_flag, out_res.trigger_count, out_res.info_nibble, out_res.wave_length,
		out_res.time_stamp, out_res.error_mask};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_of_record;

	`DBRP_ASSERT_IMP(a_stall_means_full, !s_axis_tready, item_valid)
	`DBRP_ASSERT_IMP(a_last_is_sample, m_axis_tvalid && m_axis_tlast,
		m_axis_tuser == dbrp_pkg::KIND_SAMPLE && !m_axis_tdata[148])
	`DBRP_ASSERT_IMP(a_status_no_record, m_axis_tvalid &&
		(m_axis_tuser == dbrp_pkg::KIND_STATUS || m_axis_tuser == dbrp_pkg::KIND_MISMATCH),
		m_axis_tdata[151:32] == '0 && !m_axis_tlast)
	`DBRP_ASSERT_NXT(a_full_stalled_holds_ready, item_valid && !room && !m_axis_tready,
		!s_axis_tready)

endmodule
`default_nettype wire

// ----- bench/digitizer_bank_record_parser_core_test.sv -----
// Self-checking bench for the digitizer bank record parser core: bank streams in, parsed words out.
module digitizer_bank_record_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		BANK_IDLE,
		BANK_MASK,
		REC_HDR0,
		REC_HDR1,
		REC_HDR2,
		REC_HDR3,
		REC_SAMPLES,
		BANK_SKIP
	} parse_phase_t;

	typedef struct packed {
		logic            hold;
		dbrp_pkg::item_t it;
	} pending_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [dbrp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [dbrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]                       m_axis_tuser;
	logic                             m_axis_tlast;

	digitizer_bank_record_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	pending_t        pending_words[$];
	dbrp_pkg::res_t  predicted_results[$];
	int              words_total = 0;
	int              words_accepted = 0;
	int              mismatches = 0;
	int              banks_built = 0;
	int              kind_seen[8];
	int              records_closed = 0;
	int              truncated_seen = 0;
	int              cycle = 0;
	logic            quiet;
	logic            sender_idle;
	dbrp_pkg::item_t in_flight;
	pending_t        next_word;
	dbrp_pkg::res_t  parsed;
	dbrp_pkg::res_t  want;

	// parser state mirrored by the predictor
	parse_phase_t bank_phase = BANK_IDLE;
	logic [23:0]  next_index = '0;
	logic [23:0]  bank_size = '0;
	logic [31:0]  size_field = '0;
	logic [31:0]  saved_header = '0;
	logic [47:0]  saved_stamp = '0;
	logic [26:0]  samples_due = '0;

	always @(posedge clk) cycle <= cycle + 1;

	// no idling on either side through this window
	assign quiet = (cycle >= 250) && (cycle < 450);

	function automatic logic [23:0] join_pieces(input logic [31:0] w);
		return {w[27:16], w[11:0]};
	endfunction

	function automatic parse_phase_t record_or_skip();
		return ({1'b0, next_index} + 25'd4 < {1'b0, bank_size}) ? REC_HDR0 : BANK_SKIP;
	endfunction

	function automatic bit parse_bank_word(input dbrp_pkg::item_t it, output dbrp_pkg::res_t r);
		logic [26:0] wlen;
		logic [11:0] info;
		bit          produced;
		r = '0;
		produced = 1'b0;
		if (it.first_word) begin
			bank_size = it.bank_words;
			size_field = it.word;
			next_index = 24'd1;
			bank_phase = (it.bank_words < 24'd4) ? BANK_IDLE : BANK_MASK;
			return 1'b0;
		end
		if (bank_phase == BANK_IDLE || bank_phase == BANK_SKIP || next_index >= bank_size) begin
			bank_phase = BANK_IDLE;
			return 1'b0;
		end
		next_index = next_index + 24'd1;
		case (bank_phase)
		BANK_MASK: begin
			r.error_mask = it.word;
			if ((size_field >> 1) != ({8'd0, bank_size} - 32'd2)) begin
				r.kind = dbrp_pkg::KIND_MISMATCH;
				bank_phase = BANK_IDLE;
			end else begin
				r.kind = dbrp_pkg::KIND_STATUS;
				bank_phase = record_or_skip();
			end
			produced = 1'b1;
		end
		REC_HDR0: begin
			saved_header = it.word;
			bank_phase = REC_HDR1;
		end
		REC_HDR1: begin
			saved_stamp = {join_pieces(saved_header), join_pieces(it.word)};
			bank_phase = REC_HDR2;
		end
		REC_HDR2: begin
			saved_header = it.word;
			bank_phase = REC_HDR3;
		end
		REC_HDR3: begin
			wlen = {saved_header[2:0], join_pieces(it.word)};
			info = saved_header[27:16];
			r.time_stamp = saved_stamp;
			r.wave_length = wlen;
			r.info_nibble = info[3:0];
			r.trigger_count = info[7:4];
			r.wrap_flag = info[11];
			if (wlen < 27'd8 || wlen[0]) begin
				r.kind = dbrp_pkg::KIND_BAD_LEN;
				bank_phase = BANK_SKIP;
			end else begin
				r.kind = dbrp_pkg::KIND_HEADER;
				samples_due = wlen >> 1;
				r.truncated = ({3'd0, bank_size - next_index} < samples_due);
				bank_phase = REC_SAMPLES;
			end
			produced = 1'b1;
		end
		REC_SAMPLES: begin
			r.kind = dbrp_pkg::KIND_SAMPLE;
			r.sample_first = it.word[15:0];
			r.sample_second = it.word[31:16];
			if (samples_due != '0)
				samples_due = samples_due - 27'd1;
			if (samples_due == '0) begin
				r.last_of_record = 1'b1;
				bank_phase = record_or_skip();
			end else if (next_index >= bank_size) begin
				r.truncated = 1'b1;
			end
			produced = 1'b1;
		end
		default: begin
			bank_phase = BANK_IDLE;
		end
		endcase
		if (next_index >= bank_size)
			bank_phase = BANK_IDLE;
		return produced;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
	endtask

	// driver: present pending words, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (parse_bank_word(in_flight, parsed))
					predicted_results = {predicted_results, parsed};
				words_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				sender_idle = !quiet && ($urandom_range(99) < 15);
				if (pending_words.size() != 0 && !sender_idle &&
						!(pending_words[0].hold && predicted_results.size() != 0)) begin
					next_word = pending_words.pop_front();
					in_flight = next_word.it;
					s_axis_tdata <= {in_flight.bank_words, in_flight.word};
					s_axis_tuser <= in_flight.first_word;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				kind_seen[m_axis_tuser]++;
				if (m_axis_tlast)
					records_closed++;
				if (m_axis_tdata[148])
					truncated_seen++;
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result word, kind %0d", m_axis_tuser));
				end else begin
					want = predicted_results.pop_front();
					check_field("kind", 64'(m_axis_tuser), 64'(want.kind));
					check_field("error_mask", 64'(m_axis_tdata[31:0]), 64'(want.error_mask));
					check_field("time_stamp", 64'(m_axis_tdata[79:32]), 64'(want.time_stamp));
					check_field("wave_length", 64'(m_axis_tdata[106:80]),
						64'(want.wave_length));
					check_field("info_nibble", 64'(m_axis_tdata[110:107]),
						64'(want.info_nibble));
					check_field("trigger_count", 64'(m_axis_tdata[114:111]),
						64'(want.trigger_count));
					check_field("wrap_flag", 64'(m_axis_tdata[115]), 64'(want.wrap_flag));
					check_field("sample_first", 64'(m_axis_tdata[131:116]),
						64'(want.sample_first));
					check_field("sample_second", 64'(m_axis_tdata[147:132]),
						64'(want.sample_second));
					check_field("truncated", 64'(m_axis_tdata[148]), 64'(want.truncated));
					check_field("last_of_record", 64'(m_axis_tlast), 64'(want.last_of_record));
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	task automatic add_word(input logic [31:0] w, input logic first, input logic [23:0] blen,
			input logic hold);
		pending_t p;
		p.hold = hold;
		p.it.word = w;
		p.it.first_word = first;
		p.it.bank_words = blen;
		pending_words = {pending_words, p};
		words_total++;
	endtask

	// four header words with random filler around the timestamp, length and info pieces
	function automatic logic [127:0] record_header(input logic [47:0] stamp,
			input logic [26:0] wlen, input logic [11:0] info);
		logic [31:0] h0, h1, h2, h3;
		h0 = $urandom;
		h1 = $urandom;
		h2 = $urandom;
		h3 = $urandom;
		h0[11:0] = stamp[35:24];
		h0[27:16] = stamp[47:36];
		h1[11:0] = stamp[11:0];
		h1[27:16] = stamp[23:12];
		h2[2:0] = wlen[26:24];
		h2[27:16] = info;
		h3[11:0] = wlen[11:0];
		h3[27:16] = wlen[23:12];
		return {h3, h2, h1, h0};
	endfunction

	task automatic add_header(input logic [127:0] hdr);
		for (int k = 0; k < 4; k++)
			add_word(hdr[32*k +: 32], 1'b0, 24'($urandom), 1'b0);
	endtask

	task automatic add_random_bank(input logic hold);
		logic [31:0]  body[$];
		logic [127:0] hdr;
		logic [31:0]  size_w;
		logic [26:0]  wlen;
		logic [23:0]  blen;
		int           nrec, pick, nsamp, mode, nsend, extra, blen_full;
		bit           stop;
		body = {body, 32'($urandom)};
		nrec = $urandom_range(0, 3);
		stop = 0;
		for (int r = 0; r < nrec && !stop; r++) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// too short or odd length
				wlen = $urandom_range(0, 1) ? 27'($urandom_range(0, 7)) : 27'($urandom | 1);
				nsamp = $urandom_range(0, 3);
				stop = 1;
			end else if (pick < 18) begin
				// length far beyond what the bank holds
				wlen = 27'($urandom);
				wlen[0] = 1'b0;
				wlen[26] = 1'b1;
				nsamp = $urandom_range(0, 6);
				stop = 1;
			end else begin
				wlen = 27'(2 * $urandom_range(4, 12));
				nsamp = wlen >> 1;
			end
			hdr = record_header(48'({$urandom, $urandom}), wlen, 12'($urandom));
			for (int k = 0; k < 4; k++)
				body = {body, hdr[32*k +: 32]};
			for (int k = 0; k < nsamp; k++)
				body = {body, 32'($urandom)};
		end
		extra = $urandom_range(0, 6);
		for (int k = 0; k < extra; k++)
			body = {body, 32'($urandom)};
		blen_full = body.size() + 1;
		blen = 24'(blen_full);
		nsend = blen_full;
		extra = 0;
		mode = $urandom_range(99);
		if (mode < 58) begin
		end else if (mode < 70) begin
			if (blen_full > 5)
				blen = 24'(blen_full - $urandom_range(1, blen_full - 4));
			nsend = blen;
		end else if (mode < 80) begin
			extra = $urandom_range(1, 3);
		end else if (mode < 88) begin
			// claim a long bank, then cut it off with the next first word
			blen = 24'($urandom_range(blen_full, 24'hFFFFFF));
			nsend = $urandom_range(1, blen_full);
		end
		size_w = ((32'(blen) - 32'd2) << 1) | 32'($urandom_range(0, 1));
		if (mode >= 88 && mode < 94) begin
			size_w = $urandom;
			if (size_w[31:1] == 31'(32'(blen) - 32'd2))
				size_w[1] = ~size_w[1];
		end else if (mode >= 94) begin
			blen = 24'($urandom_range(0, 3));
			nsend = $urandom_range(1, 5);
			size_w = $urandom;
		end
		if ($urandom_range(99) < 5)
			add_word($urandom, 1'b0, 24'($urandom), 1'b0);
		add_word(size_w, 1'b1, blen, hold);
		for (int k = 1; k < nsend; k++)
			add_word((k - 1 < body.size()) ? body[k - 1] : $urandom, 1'b0, 24'($urandom),
				1'b0);
		for (int k = 0; k < extra; k++)
			add_word($urandom, 1'b0, 24'($urandom), 1'b0);
		banks_built++;
	endtask

	initial begin
		// stray word with no bank open
		add_word(32'hFFFF_FFFF, 1'b0, 24'hFFFFFF, 1'b0);
		// short bank: ignored whole
		add_word(32'h0, 1'b1, 24'd3, 1'b0);
		add_word($urandom, 1'b0, 24'($urandom), 1'b0);
		add_word($urandom, 1'b0, 24'($urandom), 1'b0);
		// size word disagrees with the length, then an early first word
		add_word(32'h0, 1'b1, 24'd4, 1'b0);
		add_word(32'hFFFF_FFFF, 1'b0, 24'h0, 1'b0);
		// one full record, all-ones timestamp and info fields, extreme samples
		add_word(32'd16, 1'b1, 24'd10, 1'b1);
		add_word(32'h0, 1'b0, 24'h0, 1'b0);
		add_header(record_header(48'hFFFF_FFFF_FFFF, 27'd8, 12'hFFF));
		add_word(32'h0, 1'b0, 24'($urandom), 1'b0);
		add_word(32'hFFFF_FFFF, 1'b0, 24'($urandom), 1'b0);
		add_word(32'hFFFF_0000, 1'b0, 24'($urandom), 1'b0);
		add_word(32'h0000_FFFF, 1'b0, 24'($urandom), 1'b0);
		// odd maximum length, then a word after the bad record
		add_word(32'd10, 1'b1, 24'd7, 1'b0);
		add_word($urandom, 1'b0, 24'($urandom), 1'b0);
		add_header(record_header(48'h0, 27'h7FF_FFFF, 12'h000));
		add_word($urandom, 1'b0, 24'($urandom), 1'b0);
		banks_built = 4;

		while (words_total < 480)
			add_random_bank(banks_built % 6 == 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (words_accepted != words_total)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d words in %0d banks: %0d status, %0d size mismatch, %0d header,",
			words_total, banks_built, kind_seen[dbrp_pkg::KIND_STATUS],
			kind_seen[dbrp_pkg::KIND_MISMATCH], kind_seen[dbrp_pkg::KIND_HEADER]);
		$display("  %0d bad length, %0d sample pairs, %0d records closed, %0d truncated",
			kind_seen[dbrp_pkg::KIND_BAD_LEN], kind_seen[dbrp_pkg::KIND_SAMPLE],
			records_closed, truncated_seen);
		if (mismatches == 0) begin
			$display("PASS digitizer_bank_record_parser_core");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL digitizer_bank_record_parser_core");
		end
		$finish;
	end

	initial begin
		#500_000;
		$display("timeout with %0d of %0d words accepted", words_accepted, words_total);
		$display("FAIL digitizer_bank_record_parser_core");
		$finish;
	end

endmodule
